// ===== src/ptsch_pkg.sv =====
// types, codes and constants shared by the periodic tick scheduler
`default_nettype none
package ptsch_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 8;
  localparam int PERIOD_W = 32;
  localparam int TICK_W   = 10;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int TIME_W   = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 10;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REG   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNREG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_FIRE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TICK     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REG      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNREG    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ACK      = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOOK_EN = 1'd1;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_t;

  typedef struct packed {
    logic vld;
    logic hit;
  } token_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   tick_ms;
  } bcast_t;

  typedef struct packed {
    logic                fire;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
  } report_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] fired_handle;
    logic [TIME_W-1:0]   time_ms;
    logic                hook_call;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ptsch_if.sv =====
// valid/ready channel interfaces for commands and results
`default_nettype none
interface ptsch_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptsch_pkg::CMD_W-1:0]    cmd;
  logic [ptsch_pkg::HANDLE_W-1:0] handle;
  logic [ptsch_pkg::PERIOD_W-1:0] period_ms;

  modport source (output valid, output cmd, output handle, output period_ms, input ready);
  modport sink (input valid, input cmd, input handle, input period_ms, output ready);
endinterface

interface ptsch_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptsch_pkg::STATUS_W-1:0] status;
  logic [ptsch_pkg::SLOT_W-1:0]   slot;
  logic [ptsch_pkg::HANDLE_W-1:0] fired_handle;
  logic [ptsch_pkg::TIME_W-1:0]   time_ms;
  logic                          hook_call;
  logic                          last;

  modport source (output valid, output status, output slot, output fired_handle,
                  output time_ms, output hook_call, output last, input ready);
  modport sink (input valid, input status, input slot, input fired_handle,
                input time_ms, input hook_call, input last, output ready);
endinterface
`default_nettype wire

// ===== src/ptsch_cell.sv =====
// one slot of the table, acting when the walking token sits in it
`default_nettype none
module ptsch_cell #(
  parameter int IDX = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  ptsch_pkg::bcast_t    bc,
  input  ptsch_pkg::token_t    tok_in,
  output ptsch_pkg::token_t    tok_out,
  output ptsch_pkg::report_t   rep
);

  ptsch_pkg::token_t tok_r;
  logic [ptsch_pkg::HANDLE_W-1:0] handle_r, handle_nxt;
  logic [ptsch_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [ptsch_pkg::PERIOD_W-1:0] accum_r, accum_nxt;

  logic                           act;
  logic                           occupied;
  logic [ptsch_pkg::PERIOD_W-1:0] sum;
  logic [ptsch_pkg::PERIOD_W:0]   diff;
  logic                           fire;
  logic                           reg_hit;
  logic                           unreg_hit;

  assign act      = step && tok_r.vld;
  assign occupied = (handle_r != '0);
  assign sum      = accum_r + ptsch_pkg::PERIOD_W'(bc.tick_ms);
  assign diff     = {1'b0, sum} - {1'b0, period_r};
  assign fire     = (bc.cmd == ptsch_pkg::CMD_TICK) && occupied && !diff[ptsch_pkg::PERIOD_W];
  assign reg_hit  = (bc.cmd == ptsch_pkg::CMD_REG) && !tok_r.hit && !occupied;
  assign unreg_hit = (bc.cmd == ptsch_pkg::CMD_UNREG) && !tok_r.hit && (handle_r == bc.handle);

  always_comb begin
    handle_nxt = handle_r;
    period_nxt = period_r;
    accum_nxt  = accum_r;
    if (act) begin
      if (bc.cmd == ptsch_pkg::CMD_TICK && occupied) begin
        accum_nxt = fire ? diff[ptsch_pkg::PERIOD_W-1:0] : sum;
      end
      if (reg_hit) begin
        handle_nxt = bc.handle;
        period_nxt = bc.period;
        accum_nxt  = '0;
      end
      if (unreg_hit) begin
        handle_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      handle_r <= '0;
    end else begin
      if (step) begin
        tok_r <= tok_in;
      end
      handle_r <= handle_nxt;
    end
    period_r <= period_nxt;
    accum_r  <= accum_nxt;
  end

  assign tok_out.vld = tok_r.vld;
  assign tok_out.hit = tok_r.hit || reg_hit || unreg_hit;

  assign rep.fire   = act && fire;
  assign rep.hit    = act && (reg_hit || unreg_hit);
  assign rep.slot   = (act && (fire || reg_hit || unreg_hit)) ? ptsch_pkg::SLOT_W'(IDX) : '0;
  assign rep.handle = (act && fire) ? handle_r : '0;

endmodule
`default_nettype wire

// ===== src/periodic_tick_scheduler.sv =====
// periodic tick scheduler top level: controller, slot chain and result register
// Tick, register and unregister commands walk a token through the chain of
// NUM_SLOTS slot cells, one cell per cycle while results are taken at once;
// a fire result waiting on the output holds the walk. Start, stop, unused
// codes and a tick while stopped load their one closing result as they are
// taken in, with no walk. Fires come out in slot order and every command
// ends with one result marked last.
`default_nettype none
module periodic_tick_scheduler #(
  parameter int NUM_SLOTS = ptsch_pkg::NUM_SLOTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  ptsch_in_if.sink                           in_ch,
  ptsch_out_if.source                        out_ch,
  input  wire                                cfg_we,
  input  wire  [ptsch_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire  [ptsch_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  ptsch_pkg::fsm_t state_r, state_nxt;

  logic [ptsch_pkg::TICK_W-1:0]   tick_ms_r;
  logic                           hook_en_r;
  logic [ptsch_pkg::TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic                           running_r, running_nxt;

  logic [ptsch_pkg::CMD_W-1:0]    cmd_r;
  logic [ptsch_pkg::HANDLE_W-1:0] handle_r;
  logic [ptsch_pkg::PERIOD_W-1:0] period_r;
  logic [ptsch_pkg::SLOT_W-1:0]   hit_slot_r;
  ptsch_pkg::token_t              end_tok_r;

  ptsch_pkg::result_t             res_r, res_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic                           out_load;

  logic                           accept;
  logic                           out_free;
  logic                           need_scan;
  logic                           start;
  logic                           scan_step;
  logic                           step;

  ptsch_pkg::bcast_t              bc;
  ptsch_pkg::token_t              start_tok;
  ptsch_pkg::token_t              tok_out [NUM_SLOTS];
  ptsch_pkg::report_t             rep_vec [NUM_SLOTS];
  ptsch_pkg::report_t             rep;
  logic [NUM_SLOTS-1:0]           tok_vld;

  // handshake
  assign out_free    = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == ptsch_pkg::FSM_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign need_scan   = ((in_ch.cmd == ptsch_pkg::CMD_TICK) && running_r) ||
                       (in_ch.cmd == ptsch_pkg::CMD_REG) ||
                       (in_ch.cmd == ptsch_pkg::CMD_UNREG);
  assign start       = accept && need_scan;
  assign scan_step   = (state_r == ptsch_pkg::FSM_SCAN) && out_free;
  assign step        = scan_step || start;

  // slot chain
  assign bc.cmd     = cmd_r;
  assign bc.handle  = handle_r;
  assign bc.period  = period_r;
  assign bc.tick_ms = tick_ms_r;

  assign start_tok.vld = start;
  assign start_tok.hit = 1'b0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptsch_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .bc      (bc),
      .tok_in  ((i == 0) ? start_tok : tok_out[(i == 0) ? 0 : i-1]),
      .tok_out (tok_out[i]),
      .rep     (rep_vec[i])
    );
    assign tok_vld[i] = tok_out[i].vld;
  end

  always_comb begin
    rep = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rep = rep | rep_vec[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptsch_pkg::FSM_IDLE: begin
        if (start) begin
          state_nxt = ptsch_pkg::FSM_SCAN;
        end
      end
      ptsch_pkg::FSM_SCAN: begin
        if (scan_step && end_tok_r.vld) begin
          state_nxt = ptsch_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = ptsch_pkg::FSM_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    elapsed_nxt = elapsed_r;
    running_nxt = running_r;
    res_nxt     = res_r;
    out_load    = 1'b0;

    if (accept) begin
      if (in_ch.cmd == ptsch_pkg::CMD_TICK) begin
        elapsed_nxt = elapsed_r + ptsch_pkg::TIME_W'(tick_ms_r);
      end
      if (!need_scan) begin
        out_load             = 1'b1;
        res_nxt              = '0;
        res_nxt.status       = (in_ch.cmd == ptsch_pkg::CMD_TICK) ? ptsch_pkg::ST_TICK
                                                                 : ptsch_pkg::ST_ACK;
        res_nxt.time_ms      = elapsed_nxt;
        res_nxt.last         = 1'b1;
        unique case (in_ch.cmd)
          ptsch_pkg::CMD_START: running_nxt = 1'b1;
          ptsch_pkg::CMD_STOP:  running_nxt = 1'b0;
          default:              running_nxt = running_r;
        endcase
      end
    end

    if (scan_step) begin
      if (rep.hit && (cmd_r == ptsch_pkg::CMD_REG)) begin
        running_nxt = 1'b1;
      end
      if (rep.fire) begin
        out_load             = 1'b1;
        res_nxt              = '0;
        res_nxt.status       = ptsch_pkg::ST_FIRE;
        res_nxt.slot         = rep.slot;
        res_nxt.fired_handle = rep.handle;
        res_nxt.time_ms      = elapsed_r;
      end else if (end_tok_r.vld) begin
        out_load        = 1'b1;
        res_nxt         = '0;
        res_nxt.time_ms = elapsed_r;
        res_nxt.last    = 1'b1;
        unique case (cmd_r)
          ptsch_pkg::CMD_TICK: begin
            res_nxt.status    = ptsch_pkg::ST_TICK;
            res_nxt.hook_call = hook_en_r;
          end
          ptsch_pkg::CMD_REG: begin
            res_nxt.status = end_tok_r.hit ? ptsch_pkg::ST_REG : ptsch_pkg::ST_FULL;
            res_nxt.slot   = end_tok_r.hit ? hit_slot_r : '0;
          end
          default: begin
            res_nxt.status = end_tok_r.hit ? ptsch_pkg::ST_UNREG : ptsch_pkg::ST_NOTFOUND;
            res_nxt.slot   = end_tok_r.hit ? hit_slot_r : '0;
          end
        endcase
      end
    end

    out_vld_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ptsch_pkg::FSM_IDLE;
      tick_ms_r <= ptsch_pkg::TICK_W'(1);
      hook_en_r <= 1'b0;
      elapsed_r <= '0;
      running_r <= 1'b0;
      out_vld_r <= 1'b0;
      end_tok_r <= '0;
    end else begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      running_r <= running_nxt;
      out_vld_r <= out_vld_nxt;
      if (step) begin
        end_tok_r <= tok_out[NUM_SLOTS-1];
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          ptsch_pkg::CFG_TICK_MS: tick_ms_r <= cfg_wdata;
          ptsch_pkg::CFG_HOOK_EN: hook_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    res_r <= res_nxt;
    if (accept) begin
      cmd_r    <= in_ch.cmd;
      handle_r <= in_ch.handle;
      period_r <= in_ch.period_ms;
    end
    if (scan_step && rep.hit) begin
      hit_slot_r <= rep.slot;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.slot         = res_r.slot;
  assign out_ch.fired_handle = res_r.fired_handle;
  assign out_ch.time_ms      = res_r.time_ms;
  assign out_ch.hook_call    = res_r.hook_call;
  assign out_ch.last         = res_r.last;

  // at most one token on the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vld, end_tok_r.vld}))
    else $error("more than one token on the slot chain");

  // a walk starts in the first cell
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> tok_vld[0] && (state_r == ptsch_pkg::FSM_SCAN))
    else $error("walk did not start at the first cell");

  // fires only while a tick walks the chain
  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    rep.fire |-> (cmd_r == ptsch_pkg::CMD_TICK) && (state_r == ptsch_pkg::FSM_SCAN))
    else $error("fire outside a tick walk");

  // a successful register sets the running flag
  a_reg_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_step && rep.hit && (cmd_r == ptsch_pkg::CMD_REG)) |=> running_r)
    else $error("register did not set running");

endmodule
`default_nettype wire
